/* hdl/bdlp_pkg.sv */
package bdlp_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int COUNT_W     = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [COUNT_W-1:0] LONG_TICKS_RESET = 8'd15;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'd255;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_EDGE = 2'd1;
  localparam logic [1:0] EV_TICK = 2'd2;

  localparam logic [1:0] OP_NONE       = 2'd0;
  localparam logic [1:0] OP_TAKE_SHORT = 2'd1;
  localparam logic [1:0] OP_TAKE_LONG  = 2'd2;
  localparam logic [1:0] OP_CLEAR      = 2'd3;

  localparam logic [1:0] NO_BUTTON = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_EN          = 1'd1;

  typedef struct packed {
    logic [1:0]             event_kind;
    logic [1:0]             edge_button;
    logic [NUM_BUTTONS-1:0] levels;
    logic [1:0]             opcode;
    logic [1:0]             take_button;
  } cmd_t;

  typedef struct packed {
    logic                   took;
    logic                   beep;
    logic [NUM_BUTTONS-1:0] short_pending;
    logic [NUM_BUTTONS-1:0] long_pending;
    logic                   busy_res;
  } rsp_t;

endpackage

/* hdl/bdlp_channels.sv */
interface bdlp_cmd_if;
  logic             valid;
  logic             ready;
  bdlp_pkg::cmd_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bdlp_rsp_if;
  logic             valid;
  logic             ready;
  bdlp_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/button_debounce_long_press.sv */
// Channel  Dir  Payload                                                   Handshake
// cmd      in   event_kind, edge_button, levels, opcode, take_button      valid/ready
// rsp      out  took, beep, short_pending, long_pending, busy_res        valid/ready
// cfg      in   cfg_index (0 long_press_ticks, 1 beep enable), data      cfg_we only
//
// Each transaction on cmd updates the press state in the cycle it is accepted, and its
// result is offered on rsp in the following cycle, so with rsp ready one transaction per cycle
// is sustained. A two-entry result buffer sets cmd.ready: it is low only when both entries are waiting.
// Reset is synchronous and restores the idle state, clears all flags and reloads the registers.

module button_debounce_long_press (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0] cfg_data,
  bdlp_cmd_if.sink                        cmd,
  bdlp_rsp_if.source                      rsp
);

  logic           accept;
  logic           not_full;
  bdlp_pkg::rsp_t result;

  assign cmd.ready = not_full;
  assign accept    = cmd.valid && not_full;

  bdlp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd.data),
    .rsp       (result)
  );

  bdlp_rsp_buf u_rsp_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .not_full  (not_full),
    .rsp       (rsp)
  );

endmodule

/* hdl/bdlp_core.sv */
module bdlp_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 accept,
  input  bdlp_pkg::cmd_t                       cmd,
  output bdlp_pkg::rsp_t                       rsp
);

  logic [bdlp_pkg::COUNT_W-1:0]     long_press_ticks;
  logic                             beep_en;

  logic                             ready;
  logic                             confirmed;
  logic [1:0]                       active_button;
  logic [bdlp_pkg::COUNT_W-1:0]     hold_count;
  logic [bdlp_pkg::NUM_BUTTONS-1:0] short_flags;
  logic [bdlp_pkg::NUM_BUTTONS-1:0] long_flags;

  logic                             ready_next;
  logic                             confirmed_next;
  logic [1:0]                       active_button_next;
  logic [bdlp_pkg::COUNT_W-1:0]     hold_count_next;
  logic [bdlp_pkg::NUM_BUTTONS-1:0] short_flags_next;
  logic [bdlp_pkg::NUM_BUTTONS-1:0] long_flags_next;

  logic [bdlp_pkg::NUM_BUTTONS-1:0] active_bit;
  logic [bdlp_pkg::NUM_BUTTONS-1:0] take_bit;
  logic [bdlp_pkg::COUNT_W-1:0]     count_base;
  logic                             held;
  logic                             beep;
  logic                             took;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= bdlp_pkg::LONG_TICKS_RESET;
      beep_en          <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdlp_pkg::REG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        bdlp_pkg::REG_BEEP_EN:          beep_en          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign active_bit = bdlp_pkg::NUM_BUTTONS'(1) << active_button;
  assign take_bit   = bdlp_pkg::NUM_BUTTONS'(1) << cmd.take_button;
  assign held       = |(cmd.levels & active_bit);
  assign count_base = confirmed ? hold_count : '0;

  always_comb begin
    ready_next         = ready;
    confirmed_next     = confirmed;
    active_button_next = active_button;
    hold_count_next    = hold_count;
    short_flags_next   = short_flags;
    long_flags_next    = long_flags;
    beep               = 1'b0;
    took               = 1'b0;

    unique case (cmd.event_kind)
      bdlp_pkg::EV_EDGE: begin
        if (ready && cmd.edge_button != bdlp_pkg::NO_BUTTON) begin
          active_button_next = cmd.edge_button;
          ready_next         = 1'b0;
          confirmed_next     = 1'b0;
        end
      end
      bdlp_pkg::EV_TICK: begin
        if (!ready) begin
          if (!confirmed && !held) begin
            ready_next      = 1'b1;
            hold_count_next = '0;
          end else if (!held) begin
            short_flags_next = short_flags | active_bit;
            ready_next       = 1'b1;
            confirmed_next   = 1'b0;
            hold_count_next  = '0;
            beep             = beep_en;
          end else if (count_base > long_press_ticks) begin
            long_flags_next = long_flags | active_bit;
            ready_next      = 1'b1;
            confirmed_next  = 1'b0;
            hold_count_next = '0;
            beep            = beep_en;
          end else begin
            confirmed_next  = 1'b1;
            hold_count_next = (count_base == bdlp_pkg::COUNT_MAX) ?
                              count_base : count_base + 1'b1;
          end
        end
      end
      default: ;
    endcase

    unique case (cmd.opcode)
      bdlp_pkg::OP_CLEAR: begin
        short_flags_next = '0;
        long_flags_next  = '0;
      end
      bdlp_pkg::OP_TAKE_SHORT: begin
        if (cmd.take_button != bdlp_pkg::NO_BUTTON &&
            (short_flags_next & take_bit) != '0) begin
          short_flags_next = short_flags_next & ~take_bit;
          took             = 1'b1;
        end
      end
      bdlp_pkg::OP_TAKE_LONG: begin
        if (cmd.take_button != bdlp_pkg::NO_BUTTON &&
            (long_flags_next & take_bit) != '0) begin
          long_flags_next = long_flags_next & ~take_bit;
          took            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready         <= 1'b1;
      confirmed     <= 1'b0;
      active_button <= '0;
      hold_count    <= '0;
      short_flags   <= '0;
      long_flags    <= '0;
    end else if (accept) begin
      ready         <= ready_next;
      confirmed     <= confirmed_next;
      active_button <= active_button_next;
      hold_count    <= hold_count_next;
      short_flags   <= short_flags_next;
      long_flags    <= long_flags_next;
    end
  end

  always_comb begin
    rsp.took          = took;
    rsp.beep          = beep;
    rsp.short_pending = short_flags_next;
    rsp.long_pending  = long_flags_next;
    rsp.busy_res      = !ready_next;
  end

endmodule

/* hdl/bdlp_rsp_buf.sv */
module bdlp_rsp_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bdlp_pkg::rsp_t push_data,
  output logic           not_full,
  bdlp_rsp_if.source     rsp
);

  bdlp_pkg::rsp_t slot [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  logic           pop;

  assign pop       = rsp.valid && rsp.ready;
  assign rsp.valid = count != 2'd0;
  assign rsp.data  = slot[rd_ptr];
  assign not_full  = count != 2'd2;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* dv/tb_button_debounce_long_press.sv */
`timescale 1ns / 100ps

module tb_button_debounce_long_press;
  import bdlp_pkg::*;

  localparam logic [1:0] EV_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         SHOW_LIMIT  = 10;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bdlp_cmd_if cmd_ch ();
  bdlp_rsp_if rsp_ch ();

  button_debounce_long_press dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  // Shadow copy of the press state and registers.
  logic                   btn_idle;
  logic                   btn_confirmed;
  logic [1:0]             btn_active;
  logic [COUNT_W-1:0]     hold_ticks;
  logic [NUM_BUTTONS-1:0] short_flags;
  logic [NUM_BUTTONS-1:0] long_flags;
  logic [COUNT_W-1:0]     long_limit;
  logic                   buzzer_on;

  cmd_t button_events[$];
  rsp_t queued_reports[$];

  int  items_built;
  int  bad_reports;
  int  cycle_count;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  bit  hold_req;
  bit  src_pause;
  bit  idle_en;
  bit  cmd_accepted;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rsp_t advance_buttons(cmd_t c);
    rsp_t r;
    logic held;
    r = '0;
    if (c.event_kind == EV_EDGE) begin
      if (btn_idle && c.edge_button != NO_BUTTON) begin
        btn_active    = c.edge_button;
        btn_idle      = 1'b0;
        btn_confirmed = 1'b0;
      end
    end else if (c.event_kind == EV_TICK && !btn_idle) begin
      held = c.levels[btn_active];
      if (!btn_confirmed && !held) begin
        hold_ticks = '0;
        btn_idle   = 1'b1;
      end else begin
        if (!btn_confirmed) begin
          hold_ticks    = '0;
          btn_confirmed = 1'b1;
        end
        if (!held || hold_ticks > long_limit) begin
          if (!held) short_flags[btn_active] = 1'b1;
          else long_flags[btn_active] = 1'b1;
          r.beep        = buzzer_on;
          btn_idle      = 1'b1;
          btn_confirmed = 1'b0;
          hold_ticks    = '0;
        end else if (hold_ticks != COUNT_MAX) begin
          hold_ticks = hold_ticks + 1'b1;
        end
      end
    end

    if (c.opcode == OP_CLEAR) begin
      short_flags = '0;
      long_flags  = '0;
    end else if (c.take_button != NO_BUTTON) begin
      if (c.opcode == OP_TAKE_SHORT && short_flags[c.take_button]) begin
        short_flags[c.take_button] = 1'b0;
        r.took = 1'b1;
      end else if (c.opcode == OP_TAKE_LONG && long_flags[c.take_button]) begin
        long_flags[c.take_button] = 1'b0;
        r.took = 1'b1;
      end
    end

    r.short_pending = short_flags;
    r.long_pending  = long_flags;
    r.busy_res      = !btn_idle;
    return r;
  endfunction

  function automatic string fmt_report(rsp_t r);
    return $sformatf("took=%0d beep=%0d short=%b long=%b busy=%0d",
                     r.took, r.beep, r.short_pending, r.long_pending, r.busy_res);
  endfunction

  task automatic compare_report(rsp_t got);
    rsp_t want;
    if (queued_reports.size() == 0) begin
      bad_reports++;
      if (bad_reports <= SHOW_LIMIT)
        $display("unexpected transaction: %s", fmt_report(got));
    end else begin
      want = queued_reports.pop_front();
      if (got.took !== want.took || got.beep !== want.beep ||
          got.short_pending !== want.short_pending ||
          got.long_pending !== want.long_pending || got.busy_res !== want.busy_res) begin
        bad_reports++;
        if (bad_reports <= SHOW_LIMIT)
          $display("mismatch: expected %s, actual %s", fmt_report(want), fmt_report(got));
      end
    end
  endtask

  always @(posedge clk) begin
    cmd_accepted = 1'b0;
    if (rst) begin
      btn_idle      = 1'b1;
      btn_confirmed = 1'b0;
      btn_active    = '0;
      hold_ticks    = '0;
      short_flags   = '0;
      long_flags    = '0;
      long_limit    = LONG_TICKS_RESET;
      buzzer_on     = 1'b1;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) compare_report(rsp_ch.data);
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_PRESS_TICKS: long_limit = cfg_data;
          REG_BEEP_EN:          buzzer_on  = cfg_data[0];
          default: ;
        endcase
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        queued_reports.push_back(advance_buttons(cmd_ch.data));
        cmd_accepted = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_accepted) begin
      if (send_gap > 0) begin
        cmd_ch.valid <= 1'b0;
        send_gap--;
      end else if (!src_pause && button_events.size() > 0) begin
        cmd_ch.data  <= button_events.pop_front();
        cmd_ch.valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 199;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic push_ev(logic [1:0] kind, logic [1:0] eb, logic [2:0] lv,
                         logic [1:0] op, logic [1:0] tb);
    cmd_t c;
    c.event_kind  = kind;
    c.edge_button = eb;
    c.levels      = lv;
    c.opcode      = op;
    c.take_button = tb;
    button_events.push_back(c);
    items_built++;
  endtask

  task automatic random_request(output logic [1:0] op, output logic [1:0] tb);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) op = OP_NONE;
    else if (r < 72) op = OP_TAKE_SHORT;
    else if (r < 94) op = OP_TAKE_LONG;
    else op = OP_CLEAR;
    if ($urandom_range(0, 9) == 0) tb = NO_BUTTON;
    else tb = 2'($urandom_range(0, 2));
  endtask

  task automatic add_noise();
    push_ev(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
            2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
  endtask

  task automatic add_press(logic [1:0] b, int held_n, bit abort_it, int noise_pct);
    logic [1:0] op;
    logic [1:0] tb;
    logic [2:0] mask;
    mask = 3'b001 << b;
    random_request(op, tb);
    push_ev(EV_EDGE, b, 3'($urandom_range(0, 7)), op, tb);
    if (!abort_it) begin
      for (int i = 0; i < held_n; i++) begin
        if ($urandom_range(0, 99) < noise_pct) add_noise();
        random_request(op, tb);
        push_ev(EV_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)) | mask, op, tb);
      end
    end
    random_request(op, tb);
    push_ev(EV_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)) & ~mask, op, tb);
  endtask

  task automatic add_traffic(int n, int max_hold);
    int start;
    int r;
    start = items_built;
    while (items_built - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) add_noise();
      else if (r < 18) add_press(2'($urandom_range(0, 2)), 0, 1'b1, 0);
      else add_press(2'($urandom_range(0, 2)), $urandom_range(0, max_hold), 1'b0, 6);
    end
  endtask

  task automatic wait_quiet();
    while (button_events.size() != 0 || cmd_ch.valid || queued_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int thr;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    idle_en      = 1'b1;
    src_pause    = 1'b0;
    hold_req     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Ignored events, an aborted press and two short presses at reset settings.
    push_ev(EV_NONE, 2'd0, 3'b000, OP_TAKE_SHORT, 2'd0);
    push_ev(EV_EDGE, NO_BUTTON, 3'b000, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b111, OP_TAKE_LONG, NO_BUTTON);
    push_ev(EV_UNUSED, 2'd2, 3'b111, OP_CLEAR, 2'd1);
    push_ev(EV_EDGE, 2'd0, 3'b001, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b110, OP_NONE, 2'd0);
    push_ev(EV_EDGE, 2'd2, 3'b100, OP_NONE, 2'd0);
    push_ev(EV_EDGE, 2'd1, 3'b111, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b100, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b000, OP_TAKE_SHORT, 2'd2);
    push_ev(EV_EDGE, 2'd1, 3'b010, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b010, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b000, OP_NONE, 2'd0);
    push_ev(EV_NONE, 2'd0, 3'b000, OP_TAKE_LONG, 2'd1);
    wait_quiet();

    // Long presses with the smallest threshold.
    set_reg(REG_LONG_PRESS_TICKS, 8'd0);
    push_ev(EV_EDGE, 2'd0, 3'b001, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b001, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b001, OP_NONE, 2'd0);
    push_ev(EV_NONE, 2'd0, 3'b000, OP_TAKE_LONG, 2'd0);
    push_ev(EV_EDGE, 2'd1, 3'b000, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b010, OP_NONE, 2'd0);
    push_ev(EV_TICK, 2'd0, 3'b010, OP_NONE, 2'd0);
    push_ev(EV_NONE, 2'd0, 3'b000, OP_CLEAR, 2'd0);
    wait_quiet();

    set_reg(REG_LONG_PRESS_TICKS, LONG_TICKS_RESET);
    set_reg(REG_BEEP_EN, 8'd1);
    add_traffic(300, 19);
    hold_req = 1'b1;
    wait_quiet();

    set_reg(REG_LONG_PRESS_TICKS, 8'd3);
    set_reg(REG_BEEP_EN, 8'd0);
    idle_en = 1'b0;
    add_traffic(200, 8);
    wait_quiet();
    idle_en = 1'b1;

    set_reg(REG_LONG_PRESS_TICKS, 8'd0);
    set_reg(REG_BEEP_EN, 8'd1);
    add_traffic(150, 4);
    while (button_events.size() != 0) @(posedge clk);
    src_pause = 1'b1;
    add_traffic(100, 4);
    while (queued_reports.size() != 0 || cmd_ch.valid) @(posedge clk);
    src_pause = 1'b0;
    wait_quiet();

    // Largest threshold a long press can pass: the count runs up to its ceiling before the long press.
    set_reg(REG_LONG_PRESS_TICKS, 8'd254);
    add_press(2'd0, 258, 1'b0, 0);
    wait_quiet();
    set_reg(REG_BEEP_EN, 8'd0);
    add_press(2'd1, 40, 1'b0, 0);
    add_traffic(60, 6);
    wait_quiet();

    thr = $urandom_range(1, 30);
    set_reg(REG_LONG_PRESS_TICKS, 8'(thr));
    set_reg(REG_BEEP_EN, 8'd1);
    add_traffic(220, thr + 4);
    wait_quiet();

    repeat (10) @(posedge clk);
    if (bad_reports == 0 && queued_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
